// File: rtl/pvn_pkg.sv
// Shared types and constants for the polyline vertex normal block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package pvn_pkg;

    localparam int CW     = 32;      // coordinate width, Q16.16
    localparam int CF     = 16;      // coordinate fraction bits
    localparam int NF     = 14;      // normal fraction bits
    localparam int OW     = NF + 2;  // normal component width
    localparam int DW     = CW + 1;  // exact direction difference width
    localparam int QDEPTH = 4;       // front-to-back queue depth
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [CW-1:0] prev_x;
        logic signed [CW-1:0] prev_y;
        logic signed [CW-1:0] cur_x;
        logic signed [CW-1:0] cur_y;
        logic signed [CW-1:0] next_x;
        logic signed [CW-1:0] next_y;
    } point_t;

    typedef struct packed {
        logic signed [OW-1:0] normal_x;
        logic signed [OW-1:0] normal_y;
    } normal_t;

    // incoming and outgoing directions as queued between front and back
    typedef struct packed {
        logic signed [DW-1:0] ax;
        logic signed [DW-1:0] ay;
        logic signed [DW-1:0] bx;
        logic signed [DW-1:0] by;
    } dir_t;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           full;
        logic           empty;
    } q_status_t;

endpackage
`default_nettype wire

// File: rtl/pvn_norm.sv
// Pipelined 2-D vector normaliser: threshold test, block shift, digit-by-digit
// square root and restoring division. Depends on pvn_pkg.
`default_nettype none
module pvn_norm #(
    parameter int IN_W = 33,
    parameter int FB   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [IN_W-1:0]        x,
    input  wire logic signed [IN_W-1:0]        y,
    input  wire logic [15:0]                   min_length,
    output logic                               out_valid,
    output logic signed [pvn_pkg::OW-1:0]      ox,
    output logic signed [pvn_pkg::OW-1:0]      oy
);
    import pvn_pkg::*;

    localparam int MW    = IN_W;
    localparam int PW    = $clog2(MW);
    localparam int SQ_W  = 2 * FB + 1;
    localparam int CMP_W = 2 * FB + 2 * CF + 34;
    localparam int SH_S  = (FB < CF) ? 2 * (CF - FB) : 0;
    localparam int SH_M  = (FB > CF) ? 2 * (FB - CF) : 0;
    localparam int SH_L  = (NF >= FB) ? NF - FB : 0;
    localparam int SH_R  = (FB > NF) ? FB - NF : 0;
    localparam int RND   = (2 ** SH_R) / 2;
    localparam int RSW   = NF + FB + 2;
    localparam int VW    = 30;            // shifted magnitude width
    localparam int SW    = 2 * VW + 2;    // squared sum, padded to even
    localparam int RB    = VW + 1;        // root bits
    localparam int RW    = RB + 3;        // root remainder width
    localparam int QB    = NF + 1;        // quotient bits
    localparam int NW    = VW + NF + 1;   // dividend width
    localparam int DRW   = RB + 2;        // divide remainder width

    typedef struct packed {
        logic          nx;
        logic          ny;
        logic          below;
        logic [NF:0]   smx;
        logic [NF:0]   smy;
        logic [VW-1:0] vx;
        logic [VW-1:0] vy;
    } side_t;

    // stage 0: magnitudes
    logic            s0_v_reg;
    logic [MW-1:0]   s0_ux_reg, s0_uy_reg;
    logic            s0_nx_reg, s0_ny_reg;
    // stage 1: small-vector square, max magnitude
    logic            s1_v_reg;
    logic [MW-1:0]   s1_ux_reg, s1_uy_reg, s1_m_reg;
    logic            s1_nx_reg, s1_ny_reg, s1_lt_reg;
    logic [SQ_W-1:0] s1_sq_reg;
    logic [31:0]     s1_ml2_reg;
    // stage 2: threshold decision, leading one
    logic            s2_v_reg;
    logic [MW-1:0]   s2_ux_reg, s2_uy_reg;
    logic            s2_nx_reg, s2_ny_reg, s2_small_reg;
    logic [NF:0]     s2_smx_reg, s2_smy_reg;
    logic [PW-1:0]   s2_p_reg;
    // stages 3 to 5: shift, square, sum
    logic            s3_v_reg, s4_v_reg, s5_v_reg;
    side_t           s3_reg, s4_reg, s5_reg;
    logic [2*VW-1:0] s4_qx_reg, s4_qy_reg;
    logic [SW-1:0]   s5_s_reg;

    logic [PW-1:0]   p_next;
    logic [MW-1:0]   m_next;
    logic [NF:0]     smx_next, smy_next;
    logic            small_next;
    logic [VW-1:0]   vx_next, vy_next;

    // square-root stages
    logic            sq_v_reg    [0:RB];
    side_t           sq_side_reg [0:RB];
    logic [SW-1:0]   sq_s_reg    [0:RB];
    logic [RW-1:0]   sq_rem_reg  [0:RB];
    logic [RB-1:0]   sq_root_reg [0:RB];

    // division stages
    logic            dv_v_reg    [0:QB];
    side_t           dv_side_reg [0:QB];
    logic [RB-1:0]   dv_r_reg    [0:QB];
    logic [NW-1:0]   dv_nx_reg   [0:QB];
    logic [NW-1:0]   dv_ny_reg   [0:QB];
    logic [DRW-1:0]  dv_rx_reg   [0:QB];
    logic [DRW-1:0]  dv_ry_reg   [0:QB];
    logic [QB-1:0]   dv_qx_reg   [0:QB];
    logic [QB-1:0]   dv_qy_reg   [0:QB];

    logic [NW-1:0]   nx_next, ny_next;
    logic            out_valid_reg;
    logic signed [OW-1:0] ox_reg, oy_reg;

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= in_valid;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    // ---------------- stages 0 to 5 ----------------
    always_comb
    begin
        m_next = (s0_ux_reg > s0_uy_reg) ? s0_ux_reg : s0_uy_reg;
    end

    always_comb
    begin
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        logic [RSW-1:0]   tx;
        logic [RSW-1:0]   ty;
        lhs = CMP_W'(s1_sq_reg) << SH_S;
        rhs = CMP_W'(s1_ml2_reg) << SH_M;
        small_next = s1_lt_reg && (lhs <= rhs);
        tx = RSW'(s1_ux_reg[FB-1:0]);
        ty = RSW'(s1_uy_reg[FB-1:0]);
        if (NF >= FB)
        begin
            smx_next = (NF+1)'(tx << SH_L);
            smy_next = (NF+1)'(ty << SH_L);
        end
        else
        begin
            smx_next = (NF+1)'((tx + RSW'(RND)) >> SH_R);
            smy_next = (NF+1)'((ty + RSW'(RND)) >> SH_R);
        end
        p_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (s1_m_reg[i])
            begin
                p_next = PW'(i);
            end
        end
    end

    // bring the larger magnitude into [2^29, 2^30); right shift truncates
    always_comb
    begin
        logic [MW+VW-1:0] wx;
        logic [MW+VW-1:0] wy;
        wx = (MW+VW)'(s2_ux_reg);
        wy = (MW+VW)'(s2_uy_reg);
        if (int'(s2_p_reg) > VW - 1)
        begin
            vx_next = VW'(wx >> (int'(s2_p_reg) - (VW - 1)));
            vy_next = VW'(wy >> (int'(s2_p_reg) - (VW - 1)));
        end
        else
        begin
            vx_next = VW'(wx << ((VW - 1) - int'(s2_p_reg)));
            vy_next = VW'(wy << ((VW - 1) - int'(s2_p_reg)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ux_reg <= x[IN_W-1] ? MW'(-x) : MW'(x);
            s0_uy_reg <= y[IN_W-1] ? MW'(-y) : MW'(y);
            s0_nx_reg <= x[IN_W-1];
            s0_ny_reg <= y[IN_W-1];

            s1_ux_reg  <= s0_ux_reg;
            s1_uy_reg  <= s0_uy_reg;
            s1_nx_reg  <= s0_nx_reg;
            s1_ny_reg  <= s0_ny_reg;
            s1_m_reg   <= m_next;
            s1_lt_reg  <= ((s0_ux_reg >> FB) == '0) && ((s0_uy_reg >> FB) == '0);
            s1_sq_reg  <= SQ_W'(s0_ux_reg[FB-1:0]) * SQ_W'(s0_ux_reg[FB-1:0])
                        + SQ_W'(s0_uy_reg[FB-1:0]) * SQ_W'(s0_uy_reg[FB-1:0]);
            s1_ml2_reg <= min_length * min_length;

            s2_ux_reg    <= s1_ux_reg;
            s2_uy_reg    <= s1_uy_reg;
            s2_nx_reg    <= s1_nx_reg;
            s2_ny_reg    <= s1_ny_reg;
            s2_small_reg <= small_next;
            s2_smx_reg   <= smx_next;
            s2_smy_reg   <= smy_next;
            s2_p_reg     <= p_next;

            s3_reg.nx    <= s2_nx_reg;
            s3_reg.ny    <= s2_ny_reg;
            s3_reg.below <= s2_small_reg;
            s3_reg.smx   <= s2_smx_reg;
            s3_reg.smy   <= s2_smy_reg;
            s3_reg.vx    <= vx_next;
            s3_reg.vy    <= vy_next;

            s4_reg    <= s3_reg;
            s4_qx_reg <= s3_reg.vx * s3_reg.vx;
            s4_qy_reg <= s3_reg.vy * s3_reg.vy;

            s5_reg   <= s4_reg;
            s5_s_reg <= SW'(s4_qx_reg) + SW'(s4_qy_reg);
        end
    end

    // ---------------- square root, one root bit a stage ----------------
    always_comb
    begin
        sq_v_reg[0]    = s5_v_reg;
        sq_side_reg[0] = s5_reg;
        sq_s_reg[0]    = s5_s_reg;
        sq_rem_reg[0]  = '0;
        sq_root_reg[0] = '0;
    end

    for (genvar k = 0; k < RB; k++)
    begin : g_sqrt
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        assign cur   = {sq_rem_reg[k][RW-3:0], sq_s_reg[k][SW-1-2*k -: 2]};
        assign trial = RW'({sq_root_reg[k], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_s_reg[k+1]    <= sq_s_reg[k];
                if (cur >= trial)
                begin
                    sq_rem_reg[k+1]  <= cur - trial;
                    sq_root_reg[k+1] <= {sq_root_reg[k][RB-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k+1]  <= cur;
                    sq_root_reg[k+1] <= {sq_root_reg[k][RB-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- division, one quotient bit a stage ----------------
    always_comb
    begin
        nx_next = (NW'(sq_side_reg[RB].vx) << NF) + NW'(sq_root_reg[RB] >> 1);
        ny_next = (NW'(sq_side_reg[RB].vy) << NF) + NW'(sq_root_reg[RB] >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= sq_v_reg[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= sq_side_reg[RB];
            dv_r_reg[0]    <= sq_root_reg[RB];
            dv_nx_reg[0]   <= nx_next;
            dv_ny_reg[0]   <= ny_next;
            dv_rx_reg[0]   <= DRW'(nx_next >> QB);
            dv_ry_reg[0]   <= DRW'(ny_next >> QB);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [DRW-1:0] cx;
        logic [DRW-1:0] cy;
        logic [DRW-1:0] rr;
        assign cx = {dv_rx_reg[j][DRW-2:0], dv_nx_reg[j][QB-1-j]};
        assign cy = {dv_ry_reg[j][DRW-2:0], dv_ny_reg[j][QB-1-j]};
        assign rr = DRW'(dv_r_reg[j]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                dv_r_reg[j+1]    <= dv_r_reg[j];
                dv_nx_reg[j+1]   <= dv_nx_reg[j];
                dv_ny_reg[j+1]   <= dv_ny_reg[j];
                dv_rx_reg[j+1]   <= (cx >= rr) ? cx - rr : cx;
                dv_ry_reg[j+1]   <= (cy >= rr) ? cy - rr : cy;
                dv_qx_reg[j+1]   <= {dv_qx_reg[j][QB-2:0], cx >= rr};
                dv_qy_reg[j+1]   <= {dv_qy_reg[j][QB-2:0], cy >= rr};
            end
        end
    end

    // ---------------- sign and small-vector selection ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [NF:0] mx;
        logic [NF:0] my;
        if (en)
        begin
            mx = dv_side_reg[QB].below ? dv_side_reg[QB].smx : dv_qx_reg[QB];
            my = dv_side_reg[QB].below ? dv_side_reg[QB].smy : dv_qy_reg[QB];
            ox_reg <= dv_side_reg[QB].nx ? -signed'(OW'(mx)) : signed'(OW'(mx));
            oy_reg <= dv_side_reg[QB].ny ? -signed'(OW'(my)) : signed'(OW'(my));
        end
    end

    assign out_valid = out_valid_reg;
    assign ox        = ox_reg;
    assign oy        = oy_reg;

endmodule
`default_nettype wire

// File: rtl/pvn_fifo.sv
// Short queue of direction pairs between the front and back parts.
// Depends on pvn_pkg.
`default_nettype none
module pvn_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire pvn_pkg::dir_t      wdata,
    input  wire logic               pop,
    output pvn_pkg::dir_t           rdata,
    output pvn_pkg::q_status_t      status
);
    import pvn_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    dir_t            mem_reg [0:QDEPTH-1];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [QCW-1:0]  count_reg, count_next;
    logic            do_push, do_pop;

    assign do_push = push && (count_reg != QCW'(QDEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_next    = do_push ? AW'(wr_reg + 1'b1) : wr_reg;
        rd_next    = do_pop ? AW'(rd_reg + 1'b1) : rd_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    assign rdata        = mem_reg[rd_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCW'(QDEPTH));
    assign status.empty = (count_reg == '0);

endmodule
`default_nettype wire

// File: rtl/pvn_front.sv
// Front part: takes point triples and forms the exact incoming and
// outgoing directions. Depends on pvn_pkg.
`default_nettype none
module pvn_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                point_valid,
    output logic                     point_ready,
    input  wire pvn_pkg::point_t     point,
    input  wire pvn_pkg::q_status_t  q_status,
    output logic                     push,
    output pvn_pkg::dir_t            dir
);
    import pvn_pkg::*;

    logic  valid_reg, valid_next;
    dir_t  dir_reg;
    logic  take;

    assign push        = valid_reg && !q_status.full;
    assign point_ready = !valid_reg || !q_status.full;
    assign take        = point_valid && point_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dir_reg.ax <= DW'(point.cur_x) - DW'(point.prev_x);
            dir_reg.ay <= DW'(point.cur_y) - DW'(point.prev_y);
            dir_reg.bx <= DW'(point.next_x) - DW'(point.cur_x);
            dir_reg.by <= DW'(point.next_y) - DW'(point.cur_y);
        end
    end

    assign dir = dir_reg;

endmodule
`default_nettype wire

// File: rtl/pvn_back.sv
// Back part: normalises both directions, then their sum, and holds the
// perpendicular in the output register. Depends on pvn_pkg and pvn_norm.
`default_nettype none
module pvn_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [15:0]         min_length,
    input  wire pvn_pkg::q_status_t  q_status,
    input  wire pvn_pkg::dir_t       dir,
    output logic                     pop,
    output logic                     normal_valid,
    input  wire logic                normal_ready,
    output pvn_pkg::normal_t         normal
);
    import pvn_pkg::*;

    logic                 en;
    logic                 a_valid, b_valid, s_valid;
    logic signed [OW-1:0] ax, ay, bx, by, sx, sy;
    logic signed [OW:0]   sum_x, sum_y;
    logic                 valid_reg;
    normal_t              normal_reg;

    // the whole pipeline holds while a finished result waits
    assign en  = !valid_reg || normal_ready;
    assign pop = en && !q_status.empty;

    pvn_norm #(.IN_W(DW), .FB(CF)) u_norm_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(!q_status.empty),
        .x(dir.ax), .y(dir.ay), .min_length(min_length),
        .out_valid(a_valid), .ox(ax), .oy(ay)
    );

    pvn_norm #(.IN_W(DW), .FB(CF)) u_norm_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(!q_status.empty),
        .x(dir.bx), .y(dir.by), .min_length(min_length),
        .out_valid(b_valid), .ox(bx), .oy(by)
    );

    assign sum_x = (OW+1)'(ax) + (OW+1)'(bx);
    assign sum_y = (OW+1)'(ay) + (OW+1)'(by);

    pvn_norm #(.IN_W(OW+1), .FB(NF)) u_norm_s (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_valid && b_valid),
        .x(sum_x), .y(sum_y), .min_length(min_length),
        .out_valid(s_valid), .ox(sx), .oy(sy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            normal_reg.normal_x <= -sy;
            normal_reg.normal_y <= sx;
        end
    end

    assign normal_valid = valid_reg;
    assign normal       = normal_reg;

endmodule
`default_nettype wire

// File: rtl/polyline_vertex_normal.sv
// Path from point transfer to normal_valid: front register, queue, two 54-stage
// normalisers in series, output register.
// Throughput: one transfer per cycle, set by the fully pipelined square-root
// and division stages; a stalled output holds the whole back pipeline.
// Reset: asynchronous, active low; clears handshake state and min_length.
// Depends on pvn_pkg, pvn_front, pvn_fifo and pvn_back.
`default_nettype none
module polyline_vertex_normal (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              point_valid,
    output logic                   point_ready,
    input  wire pvn_pkg::point_t   point,
    output logic                   normal_valid,
    input  wire logic              normal_ready,
    output pvn_pkg::normal_t       normal,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import pvn_pkg::*;

    logic        [15:0] min_length_reg;
    logic               cfg_wr;
    logic               push, pop;
    dir_t               f_dir, q_dir;
    q_status_t          q_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {16'd0, min_length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= '0;
        end
        else if (cfg_wr)
        begin
            min_length_reg <= pwdata[15:0];
        end
    end

    pvn_front u_front (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .q_status(q_status), .push(push), .dir(f_dir)
    );

    pvn_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .wdata(f_dir), .pop(pop), .rdata(q_dir), .status(q_status)
    );

    pvn_back u_back (
        .clk(clk), .rst_n(rst_n), .min_length(min_length_reg),
        .q_status(q_status), .dir(q_dir), .pop(pop),
        .normal_valid(normal_valid), .normal_ready(normal_ready), .normal(normal)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCW'(QDEPTH))
        else $error("queue occupancy beyond depth");

    a_queue_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("front pushed into a full queue");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> min_length_reg == $past(pwdata[15:0]))
        else $error("min_length write lost");

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for polyline_vertex_normal: drives point triples, predicts the
// miter normal in fixed point and compares every normal transfer in order.
// Depends on pvn_pkg and the RTL top level only.
`timescale 1ns / 1ps
module testbench;
    import pvn_pkg::*;

    localparam int  LATENCY    = 110;
    localparam int  RAND_ITEMS = 1200;
    localparam int  CYCLE_CAP  = 400000;
    localparam logic [2:0] ADDR_MIN_LENGTH = 3'd0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic point_valid = 1'b0;
    logic point_ready;
    point_t point = '0;
    logic normal_valid;
    logic normal_ready = 1'b0;
    normal_t normal;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    polyline_vertex_normal dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .normal_valid(normal_valid), .normal_ready(normal_ready), .normal(normal),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [15:0] min_len = '0;
    normal_t     expected_normals[$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    // ---------------- predictor ----------------
    function automatic logic [63:0] isqrt(logic [63:0] s);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] to_q14(logic [63:0] mag, int fb);
        int sh;
        if (NF >= fb) return mag << (NF - fb);
        sh = fb - NF;
        return (mag + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic void unit_vec(longint x, longint y, int fb,
                                     output longint ox, output longint oy);
        logic [63:0] ux, uy, m, s, r, t;
        bit nx, ny, below;
        nx = x < 0;
        ny = y < 0;
        ux = nx ? -x : x;
        uy = ny ? -y : y;
        if (ux < (64'd1 << fb) && uy < (64'd1 << fb))
        begin
            s = ux * ux + uy * uy;
            if (fb >= CF)
            begin
                t = 64'(min_len) << (fb - CF);
                below = s <= t * t;
            end
            else
                below = (s << (2 * (CF - fb))) <= 64'(min_len) * 64'(min_len);
            if (below)
            begin
                ox = nx ? -longint'(to_q14(ux, fb)) : longint'(to_q14(ux, fb));
                oy = ny ? -longint'(to_q14(uy, fb)) : longint'(to_q14(uy, fb));
                return;
            end
        end
        m = ux > uy ? ux : uy;
        while (m >= (64'd1 << 30))
        begin
            ux >>= 1; uy >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            ux <<= 1; uy <<= 1; m <<= 1;
        end
        r = isqrt(ux * ux + uy * uy);
        ox = longint'(((ux << NF) + (r >> 1)) / r);
        oy = longint'(((uy << NF) + (r >> 1)) / r);
        if (nx) ox = -ox;
        if (ny) oy = -oy;
    endfunction

    function automatic normal_t miter_normal(point_t p);
        longint ax, ay, bx, by, sx, sy;
        normal_t n;
        unit_vec(longint'(p.cur_x) - longint'(p.prev_x),
                 longint'(p.cur_y) - longint'(p.prev_y), CF, ax, ay);
        unit_vec(longint'(p.next_x) - longint'(p.cur_x),
                 longint'(p.next_y) - longint'(p.cur_y), CF, bx, by);
        unit_vec(ax + bx, ay + by, NF, sx, sy);
        n.normal_x = OW'(-sy);
        n.normal_y = OW'(sx);
        return n;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_min_length(logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_MIN_LENGTH; pwdata <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        min_len = v;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // called at a falling edge; returns at a falling edge after the transfer
    task automatic send_point(point_t p);
        point_valid <= 1'b1;
        point <= p;
        @(posedge clk);
        while (!point_ready) @(posedge clk);
        expected_normals.push_back(miter_normal(p));
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_normals.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 20) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
            2: return 32'($urandom_range(0, 2000)) - 32'd1000;
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($urandom_range(0, 20'hfffff)) - 32'h80000;
        endcase
    endfunction

    // nearby points so that short and below-threshold directions occur often
    task automatic send_random(int n);
        point_t p;
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && n > 0)
            begin
                p.cur_x = rand_coord();
                p.cur_y = rand_coord();
                if ($urandom_range(0, 3) == 0)
                begin
                    p.prev_x = rand_coord(); p.prev_y = rand_coord();
                    p.next_x = rand_coord(); p.next_y = rand_coord();
                end
                else
                begin
                    p.prev_x = p.cur_x + 32'($signed(16'($urandom)) >>> $urandom_range(0, 15));
                    p.prev_y = p.cur_y + 32'($signed(16'($urandom)) >>> $urandom_range(0, 15));
                    p.next_x = p.cur_x + 32'($signed(16'($urandom)) >>> $urandom_range(0, 15));
                    p.next_y = p.cur_y + 32'($signed(16'($urandom)) >>> $urandom_range(0, 15));
                end
                send_point(p);
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                point_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        point_valid <= 1'b0;
    endtask

    // directed rows: prev, cur, next and, where obvious, the expected normal
    typedef struct {
        point_t  p;
        bit      known;
        normal_t n;
    } row_t;

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial
    begin
        row_t rows[$];
        row_t r;
        normal_t got_n;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // along +x: normal (0, 1); along +y: normal (-1, 0)
        r.p = '{0, 0, ONE, 0, 2*ONE, 0};       r.known = 1; r.n = '{16'sd0, 16'sd16384};
        rows.push_back(r);
        r.p = '{0, 0, 0, ONE, 0, 2*ONE};       r.known = 1; r.n = '{-16'sd16384, 16'sd0};
        rows.push_back(r);
        r.p = '{0, 0, -ONE, 0, -2*ONE, 0};     r.known = 1; r.n = '{16'sd0, -16'sd16384};
        rows.push_back(r);
        // all points equal: zero stays zero
        r.p = '{5, 5, 5, 5, 5, 5};             r.known = 1; r.n = '{16'sd0, 16'sd0};
        rows.push_back(r);
        // reversal: opposite directions cancel
        r.p = '{0, 0, ONE, 0, 0, 0};           r.known = 1; r.n = '{16'sd0, 16'sd0};
        rows.push_back(r);
        // repeated prev point: only outgoing direction counts
        r.p = '{ONE, ONE, ONE, ONE, ONE, 3*ONE}; r.known = 1; r.n = '{-16'sd16384, 16'sd0};
        rows.push_back(r);
        r.known = 0;
        r.p = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff};
        rows.push_back(r);
        r.p = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff};
        rows.push_back(r);
        r.p = '{0, 0, 1, 0, 1, 1};             rows.push_back(r);
        r.p = '{0, 0, 1, 1, 2, 0};             rows.push_back(r);
        r.p = '{0, 0, ONE, ONE, 2*ONE, 0};     rows.push_back(r);
        r.p = '{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 0, 3, 32'hffff_fffe};
        rows.push_back(r);

        foreach (rows[i])
        begin
            send_point(rows[i].p);
            if (rows[i].known)
            begin
                got_n = expected_normals[$];
                if (got_n !== rows[i].n)
                begin
                    $error("directed row %0d: predictor %h, table %h", i, got_n, rows[i].n);
                    errors++;
                end
            end
        end
        point_valid <= 1'b0;
        drain();

        send_random(RAND_ITEMS / 4);
        drain();
        // threshold cases: tiny vectors kept unnormalized, then extremes
        write_min_length(16'd3);
        r.p = '{0, 0, 1, 0, 2, 1};             send_point(r.p);
        r.p = '{0, 0, 2, 2, 4, 4};             send_point(r.p);
        send_random(RAND_ITEMS / 4);
        drain();
        write_min_length(16'hffff);
        r.p = '{0, 0, ONE - 1, 0, ONE - 1, 1}; send_point(r.p);
        r.p = '{0, 0, ONE, 0, 2*ONE, 0};       send_point(r.p);
        hold_off = 1'b1;
        send_random(RAND_ITEMS / 4);
        drain();
        write_min_length(16'h8000);
        send_random(RAND_ITEMS / 8);
        drain();
        write_min_length(16'h0);
        send_random(RAND_ITEMS / 8);
        drain();
        stim_done = 1'b1;
    end

    // receiver: stall pattern, plus one long hold-off to back up the pipeline
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                normal_ready <= 1'b0;
                for (hold = 0; hold < 600; hold++) @(negedge clk);
                hold_off = 1'b0;
            end
            case (cycles[11:10])
                2'd0: normal_ready <= 1'b1;
                2'd1: normal_ready <= ($urandom_range(0, 3) != 0);
                2'd2: normal_ready <= cycles[2];
                default: normal_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // checker
    always @(posedge clk)
    begin
        normal_t exp_n;
        cycles <= cycles + 1;
        if (rst_n && normal_valid && normal_ready)
        begin
            if (expected_normals.size() == 0)
            begin
                $error("unexpected normal %h", normal);
                errors++;
            end
            else
            begin
                exp_n = expected_normals.pop_front();
                if (normal.normal_x !== exp_n.normal_x)
                begin
                    $error("normal_x: expected %0d, got %0d", exp_n.normal_x, normal.normal_x);
                    errors++;
                end
                if (normal.normal_y !== exp_n.normal_y)
                begin
                    $error("normal_y: expected %0d, got %0d", exp_n.normal_y, normal.normal_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done || cycles >= CYCLE_CAP);
        if (stim_done && errors == 0 && expected_normals.size() == 0)
            $display("PASS polyline_vertex_normal");
        else
        begin
            if (expected_normals.size() != 0)
                $error("%0d normals never arrived", expected_normals.size());
            $display("FAIL polyline_vertex_normal");
        end
        $finish;
    end
endmodule
